// ===== design/assert_macros.svh =====
// Assertion macros shared by the status lamp sequencer RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define SLPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slps assertion failed");

// Clocked check that also holds across reset.
`define SLPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("slps assertion failed");

`endif

// ===== design/slps_pkg.sv =====
// Shared types and constants of the status lamp pattern sequencer.
// No dependencies; used by slps_cfg_regs, slps_core and the top level.
package slps_pkg;

  // Display states, same encoding as the command field.
  typedef enum logic [2:0] {
    ST_OFF      = 3'd0,
    ST_BOOTING  = 3'd1,
    ST_OK       = 3'd2,
    ST_SETUP    = 3'd3,
    ST_RADIO    = 3'd4,
    ST_ACTION   = 3'd5,
    ST_WARNING  = 3'd6,
    ST_CRITICAL = 3'd7
  } led_state_t;

  // Register map.
  localparam int unsigned ADDR_W       = 3;
  localparam logic        REG_FRAME_MS = 1'b0;
  localparam int unsigned FRAME_W      = 10;
  localparam logic [FRAME_W-1:0] FRAME_MS_RESET = 10'd100;

  // Time base and blink phases.
  localparam int unsigned TIME_W       = 32;
  localparam logic [3:0]  PHASE10_LAST = 4'd9;
  localparam logic [3:0]  BLINK_HALF   = 4'd5;
  localparam logic [3:0]  ACTION_ON    = 4'd7;
  localparam logic [1:0]  RADIO_HALF   = 2'd2;

  // One rendered frame.
  typedef struct packed {
    logic       red;
    logic       green;
    logic       yellow;
    led_state_t shown;
  } frame_out_t;

endpackage

// ===== design/status_led_pattern_sequencer.sv =====
// Top level of the status lamp pattern sequencer: input and result
// registers around slps_core, plus slps_cfg_regs. Depends on slps_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_cmd_valid, in_cmd_state, in_cmd_duration_ms
//   out      output     out_valid / out_ready out_red_on, out_green_on, out_yellow_on,
//                                             out_shown_state
//   cfg      input      psel/penable/pwrite   paddr, pwdata, prdata, pready (always high)
//
// One item per cycle sustained while out_ready is high; each item passes through
// the input register and then through the frame logic into the result
// register. Synchronous active-low reset clears the time base, states,
// phases and both valid flags; frame_ms resets to 100. When out_ready is low
// the result holds, one more item waits in the input register, and in_ready
// then drops.
`include "assert_macros.svh"

module status_led_pattern_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_cmd_valid,
  input  logic [2:0]                   in_cmd_state,
  input  logic [31:0]                  in_cmd_duration_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_red_on,
  output logic                         out_green_on,
  output logic                         out_yellow_on,
  output logic [2:0]                   out_shown_state,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slps_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_cmd_valid_r;
  logic [2:0]                   s1_cmd_state_r;
  logic [31:0]                  s1_dur_r;
  logic                         out_valid_r, out_valid_nxt;
  slps_pkg::frame_out_t         out_r;
  slps_pkg::frame_out_t         frame_out;
  logic [slps_pkg::FRAME_W-1:0] frame_ms;
  logic                         in_fire;
  logic                         s1_adv;

  slps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .frame_ms (frame_ms)
  );

  slps_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (s1_adv),
    .cmd_valid       (s1_cmd_valid_r),
    .cmd_state       (s1_cmd_state_r),
    .cmd_duration_ms (s1_dur_r),
    .frame_ms        (frame_ms),
    .frame_out       (frame_out)
  );

  // Pipeline flow control.
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !s1_valid_r || s1_adv;
  assign in_fire       = in_valid && in_ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register takes the accepted item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_valid_r <= in_cmd_valid;
      s1_cmd_state_r <= in_cmd_state;
      s1_dur_r       <= in_cmd_duration_ms;
    end
  end

  // Result register takes the rendered frame.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= frame_out;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_on      = out_r.red;
  assign out_green_on    = out_r.green;
  assign out_yellow_on   = out_r.yellow;
  assign out_shown_state = out_r.shown;

  // Checks on flow control and lamp decode.
  `SLPS_ASSERT(a_stall_only_when_full, clk, rst_n,
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
  `SLPS_ASSERT_ALWAYS(a_reset_empties, clk,
    !rst_n |=> (!s1_valid_r && !out_valid_r))
  `SLPS_ASSERT(a_off_is_dark, clk, rst_n,
    (out_valid_r && (out_r.shown == slps_pkg::ST_OFF)) |-> !(out_r.red || out_r.green || out_r.yellow))
  `SLPS_ASSERT(a_red_only_critical, clk, rst_n,
    (out_valid_r && out_r.red) |-> (out_r.shown == slps_pkg::ST_CRITICAL))

endmodule

// ===== design/slps_cfg_regs.sv =====
// APB-style configuration register block holding the frame length.
// Depends on slps_pkg for the register map.
module slps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slps_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [slps_pkg::FRAME_W-1:0]  frame_ms
);

  logic [slps_pkg::FRAME_W-1:0] frame_ms_r;
  logic [slps_pkg::FRAME_W-1:0] frame_ms_nxt;
  logic                         sel_frame;

  // The word index is the upper address bit; only index zero exists.
  assign sel_frame = (paddr[slps_pkg::ADDR_W-1] == slps_pkg::REG_FRAME_MS);

  // Write in the access phase.
  always_comb begin
    frame_ms_nxt = frame_ms_r;
    if (psel && penable && pwrite && sel_frame) begin
      frame_ms_nxt = pwdata[slps_pkg::FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ms_r <= slps_pkg::FRAME_MS_RESET;
    end else begin
      frame_ms_r <= frame_ms_nxt;
    end
  end

  // Read back; unmapped words read as zero.
  assign prdata   = sel_frame ? {{(32 - slps_pkg::FRAME_W){1'b0}}, frame_ms_r} : 32'd0;
  assign pready   = 1'b1;
  assign frame_ms = frame_ms_r;

endmodule

// ===== design/slps_core.sv =====
// Frame state: millisecond clock, temporary and persistent states, blink
// phases, and the lamp pattern decode. Depends on slps_pkg.
module slps_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          cmd_valid,
  input  logic [2:0]                    cmd_state,
  input  logic [31:0]                   cmd_duration_ms,
  input  logic [slps_pkg::FRAME_W-1:0]  frame_ms,
  output slps_pkg::frame_out_t          frame_out
);

  logic [slps_pkg::TIME_W-1:0] now_ms_r, now_ms_nxt;
  logic [slps_pkg::TIME_W-1:0] temp_end_ms_r, temp_end_ms_nxt;
  slps_pkg::led_state_t        persist_r, persist_nxt;
  slps_pkg::led_state_t        render_r, render_nxt;
  logic [3:0]                  phase_ten_r, phase_ten_nxt;
  logic [1:0]                  phase_four_r, phase_four_nxt;
  slps_pkg::led_state_t        cmd_st;
  logic                        red, green, yellow;

  assign cmd_st = slps_pkg::led_state_t'(cmd_state);

  // Command handling and the return to the persistent state.
  always_comb begin
    temp_end_ms_nxt = temp_end_ms_r;
    persist_nxt     = persist_r;
    render_nxt      = render_r;
    if (cmd_valid) begin
      if (cmd_duration_ms != 32'd0) begin
        render_nxt      = cmd_st;
        temp_end_ms_nxt = now_ms_r + cmd_duration_ms;
      end else begin
        persist_nxt = cmd_st;
        if (now_ms_r >= temp_end_ms_r) begin
          render_nxt = cmd_st;
        end
      end
    end
    // A temporary state that has run out, possibly in this very frame.
    if ((render_nxt != persist_nxt) && (now_ms_r >= temp_end_ms_nxt)) begin
      render_nxt = persist_nxt;
    end
  end

  // Blink phases step before the lamps are decoded; time steps after.
  assign phase_ten_nxt  = (phase_ten_r >= slps_pkg::PHASE10_LAST) ? 4'd0 : phase_ten_r + 4'd1;
  assign phase_four_nxt = phase_four_r + 2'd1;
  assign now_ms_nxt     = now_ms_r + {{(slps_pkg::TIME_W - slps_pkg::FRAME_W){1'b0}}, frame_ms};

  // Lamp patterns of each state.
  always_comb begin
    red    = 1'b0;
    green  = 1'b0;
    yellow = 1'b0;
    case (render_nxt)
      slps_pkg::ST_BOOTING: begin
        yellow = (phase_ten_nxt < slps_pkg::BLINK_HALF);
      end
      slps_pkg::ST_OK: begin
        green = 1'b1;
      end
      slps_pkg::ST_SETUP: begin
        yellow = (phase_ten_nxt < slps_pkg::BLINK_HALF);
        green  = !(phase_ten_nxt < slps_pkg::BLINK_HALF);
      end
      slps_pkg::ST_RADIO: begin
        green  = 1'b1;
        yellow = (phase_four_nxt < slps_pkg::RADIO_HALF);
      end
      slps_pkg::ST_ACTION: begin
        green = (phase_ten_nxt < slps_pkg::ACTION_ON);
      end
      slps_pkg::ST_WARNING: begin
        yellow = 1'b1;
      end
      slps_pkg::ST_CRITICAL: begin
        red = !phase_four_nxt[0];
      end
      default: begin
      end
    endcase
  end

  assign frame_out = '{red: red, green: green, yellow: yellow, shown: render_nxt};

  // State advances once per frame that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r      <= '0;
      temp_end_ms_r <= '0;
      persist_r     <= slps_pkg::ST_OFF;
      render_r      <= slps_pkg::ST_OFF;
      phase_ten_r   <= '0;
      phase_four_r  <= '0;
    end else if (step) begin
      now_ms_r      <= now_ms_nxt;
      temp_end_ms_r <= temp_end_ms_nxt;
      persist_r     <= persist_nxt;
      render_r      <= render_nxt;
      phase_ten_r   <= phase_ten_nxt;
      phase_four_r  <= phase_four_nxt;
    end
  end

endmodule
